// ===== design/at_rsp_pkg.sv =====
package at_rsp_pkg;

  // Line and header limits (bytes)
  localparam logic [7:0] LINE_LIMIT   = 8'd192;
  localparam logic [6:0] HEADER_LIMIT = 7'd32;

  // Keyword table: bits 0..11 are line keywords, bit 12 is the "+IPD," opener
  localparam int unsigned NKW      = 13;
  localparam int unsigned KW_MAX   = 17;
  localparam int unsigned BUSY_BIT = 11;
  localparam int unsigned IPD_BIT  = 12;

  localparam logic [NKW-1:0] ALL_ALIVE = {NKW{1'b1}};

  localparam logic [3:0] KW_OK       = 4'd0;
  localparam logic [3:0] KW_ERROR    = 4'd1;
  localparam logic [3:0] KW_FAIL     = 4'd2;
  localparam logic [3:0] KW_GOTIP    = 4'd3;
  localparam logic [3:0] KW_WIFIDISC = 4'd4;
  localparam logic [3:0] KW_WIFICONN = 4'd5;
  localparam logic [3:0] KW_ALREADY  = 4'd6;
  localparam logic [3:0] KW_CONNECT  = 4'd7;
  localparam logic [3:0] KW_CLOSED   = 4'd8;
  localparam logic [3:0] KW_SENDOK   = 4'd9;
  localparam logic [3:0] KW_READY    = 4'd10;
  localparam logic [3:0] KW_BUSY     = 4'd11;

  // Text is right-justified: character p of a keyword of length L sits in byte L-1-p
  localparam logic [KW_MAX*8-1:0] KW_TEXT [NKW] = '{
    "OK", "ERROR", "FAIL", "WIFI GOT IP", "WIFI DISCONNECT", "WIFI CONNECTED",
    "ALREADY CONNECTED", "CONNECT", "CLOSED", "SEND OK", "ready", "busy", "+IPD,"
  };
  localparam int unsigned KW_LEN [NKW] = '{2, 5, 4, 11, 15, 14, 17, 7, 6, 7, 5, 4, 5};

  // Position of the comma that completes "+IPD,"
  localparam logic [7:0] IPD_LAST_POS = 8'd4;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [19:0] LEN_MAX = 20'd65535;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_LINE    = 3'd1,
    MODE_LINE_CR = 3'd2,
    MODE_HEADER  = 3'd3,
    MODE_PAYLOAD = 3'd4,
    MODE_DISCARD = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_PAYLOAD  = 4'd1,
    EV_OK       = 4'd2,
    EV_ERROR    = 4'd3,
    EV_FAIL     = 4'd4,
    EV_GOTIP    = 4'd5,
    EV_WIFIDISC = 4'd6,
    EV_WIFICONN = 4'd7,
    EV_ALREADY  = 4'd8,
    EV_CONNECT  = 4'd9,
    EV_CLOSED   = 4'd10,
    EV_SENDOK   = 4'd11,
    EV_READY    = 4'd12,
    EV_BUSY     = 4'd13,
    EV_PROMPT   = 4'd14,
    EV_OVERFLOW = 4'd15
  } ev_t;

  typedef struct packed {
    logic [NKW-1:0] next_alive;  // survivors after this character
    logic [NKW-1:0] complete;    // keywords fully matched by the bytes so far
  } kw_match_t;

endpackage

// ===== design/at_rsp_kw_match.sv =====
module at_rsp_kw_match (
  input  logic [at_rsp_pkg::NKW-1:0] alive,
  input  logic [7:0]                 pos,
  input  logic [7:0]                 rx_byte,
  output at_rsp_pkg::kw_match_t      res
);
  import at_rsp_pkg::*;

  // One comparator per keyword against the character expected at this position
  for (genvar k = 0; k < NKW; k++) begin : g_kw
    logic       in_range;
    logic [4:0] idx;
    logic [7:0] ch;
    logic       char_hit;

    assign in_range = pos < 8'(KW_LEN[k]);
    assign idx      = 5'(KW_LEN[k] - 1) - pos[4:0];
    assign ch       = in_range ? KW_TEXT[k][{idx, 3'b000} +: 8] : 8'h00;
    assign char_hit = alive[k] & in_range & (ch == rx_byte);

    if (k == BUSY_BIT) begin : g_prefix
      // matched by prefix: stays alive once its text is through
      assign res.next_alive[k] = alive[k] & ((pos >= 8'(KW_LEN[k])) | char_hit);
      assign res.complete[k]   = alive[k] & (pos >= 8'(KW_LEN[k]));
    end else if (k == IPD_BIT) begin : g_ipd
      assign res.next_alive[k] = char_hit;
      assign res.complete[k]   = 1'b0;
    end else begin : g_exact
      assign res.next_alive[k] = char_hit;
      assign res.complete[k]   = alive[k] & (pos == 8'(KW_LEN[k]));
    end
  end

endmodule

// ===== design/at_modem_response_parser_core.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_rx_byte
// out     | output    | out_valid / out_stall| out_event_res, out_payload_byte,
//         |           |                      | out_wifi_up, out_tcp_up
//
// One transfer in gives exactly one transfer out; a byte is taken every cycle
// while in_stall is low. Its result loads with the parser state into the output
// register or, behind a stalled result, the skid entry. Throughput is set by the
// output register plus one skid entry; in_stall rises only when both hold a result.
// Reset (rst_n low, synchronous) returns the parser to line start with both flags low.
module at_modem_response_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_res,
  output logic [7:0] out_payload_byte,
  output logic       out_wifi_up,
  output logic       out_tcp_up
);
  import at_rsp_pkg::*;

  // Parser state
  mode_t          mode_r,   mode_nxt;
  logic [7:0]     cnt_r,    cnt_nxt;
  logic [NKW-1:0] alive_r,  alive_nxt;
  logic [5:0]     hdr_r,    hdr_nxt;
  logic [16:0]    len_r,    len_nxt;
  logic           len_ok_r, len_ok_nxt;
  logic [15:0]    left_r,   left_nxt;
  logic           skip_r,   skip_nxt;
  logic           wifi_r,   wifi_nxt;
  logic           tcp_r,    tcp_nxt;

  ev_t            ev_nxt;
  logic [7:0]     pay_nxt;

  // Output register and skid entry
  logic           out_valid_r;
  ev_t            out_ev_r;
  logic [7:0]     out_pay_r;
  logic           out_wifi_r;
  logic           out_tcp_r;
  logic           skid_full_r;
  ev_t            skid_ev_r;
  logic [7:0]     skid_pay_r;
  logic           skid_wifi_r;
  logic           skid_tcp_r;

  logic           in_xfer;
  logic           out_xfer;

  assign in_stall  = skid_full_r;
  assign in_xfer   = in_valid & ~skid_full_r;
  assign out_xfer  = out_valid_r & ~out_stall;

  // Line context as seen by this byte: a byte at line start opens a fresh line
  logic           in_line;
  logic [7:0]     cnt_eff;
  logic [NKW-1:0] alive_eff;
  logic           cr_eff;
  kw_match_t      km;

  assign in_line   = (mode_r == MODE_LINE) || (mode_r == MODE_LINE_CR);
  assign cnt_eff   = in_line ? cnt_r : 8'd0;
  assign alive_eff = in_line ? alive_r : ALL_ALIVE;
  assign cr_eff    = (mode_r == MODE_LINE_CR);

  at_rsp_kw_match u_kw_match (
    .alive   (alive_eff),
    .pos     (cnt_eff),
    .rx_byte (in_rx_byte),
    .res     (km)
  );

  // Line byte handling
  mode_t          line_mode;
  logic [7:0]     line_cnt;
  logic [NKW-1:0] line_alive;
  ev_t            line_ev;
  logic           line_wifi;
  logic           line_tcp;
  logic           line_hdr_open;
  logic [NKW-1:0] done_bits;
  logic           kw_found;
  logic [3:0]     kw_idx;
  logic [7:0]     cnt_bumped;

  assign cnt_bumped = (cnt_eff != 8'hFF) ? cnt_eff + 8'd1 : cnt_eff;

  always_comb begin
    // after a CR the surviving set already holds the completed keywords
    done_bits = cr_eff ? (alive_eff & ~(NKW'(1) << IPD_BIT)) : km.complete;
    kw_found  = 1'b0;
    kw_idx    = KW_OK;
    // lowest keyword wins
    for (int k = BUSY_BIT; k >= 0; k--) begin
      if (done_bits[k]) begin
        kw_found = 1'b1;
        kw_idx   = 4'(k);
      end
    end

    line_mode     = MODE_LINE;
    line_cnt      = cnt_bumped;
    line_alive    = alive_eff;
    line_ev       = EV_NONE;
    line_wifi     = wifi_r;
    line_tcp      = tcp_r;
    line_hdr_open = 1'b0;

    if (in_rx_byte == CH_LF) begin
      line_mode  = MODE_START;
      line_cnt   = 8'd0;
      line_alive = ALL_ALIVE;
      if (cnt_eff >= LINE_LIMIT) begin
        line_ev = EV_OVERFLOW;
      end else if (kw_found) begin
        line_ev = ev_t'(kw_idx + 4'd2);
        case (kw_idx)
          KW_GOTIP: begin
            line_wifi = 1'b1;
          end
          KW_WIFIDISC: begin
            line_wifi = 1'b0;
            line_tcp  = 1'b0;
          end
          KW_ALREADY, KW_CONNECT: begin
            line_tcp = 1'b1;
          end
          KW_CLOSED: begin
            line_tcp = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end else if (in_rx_byte == CH_CR) begin
      line_mode = MODE_LINE_CR;
      if (!cr_eff) begin
        line_alive = km.complete;
      end
    end else if (cr_eff) begin
      // text after a CR: only the prefix keyword can survive
      line_alive = alive_eff & (NKW'(1) << BUSY_BIT);
    end else begin
      line_alive = km.next_alive;
      if (km.next_alive[IPD_BIT] && (cnt_eff == IPD_LAST_POS)) begin
        line_mode     = MODE_HEADER;
        line_hdr_open = 1'b1;
      end
    end
  end

  // Header length digits: value times ten by shift and add
  logic        is_digit;
  logic [19:0] len_grown;
  logic [5:0]  hdr_bumped;

  assign is_digit   = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign len_grown  = 20'({len_r[15:0], 3'b000}) + 20'({len_r[15:0], 1'b0})
                    + 20'(in_rx_byte - CH_ZERO);
  assign hdr_bumped = (hdr_r != 6'd63) ? hdr_r + 6'd1 : hdr_r;

  // Next state and result for the byte on the input port
  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    alive_nxt  = alive_r;
    hdr_nxt    = hdr_r;
    len_nxt    = len_r;
    len_ok_nxt = len_ok_r;
    left_nxt   = left_r;
    skip_nxt   = 1'b0;
    wifi_nxt   = wifi_r;
    tcp_nxt    = tcp_r;
    ev_nxt     = EV_NONE;
    pay_nxt    = 8'h00;

    // drop a single space right after a prompt
    if (!(skip_r && (in_rx_byte == CH_SPACE) && (mode_r == MODE_START))) begin
      case (mode_r)
        MODE_HEADER: begin
          if (in_rx_byte == CH_COLON) begin
            mode_nxt  = MODE_START;
            cnt_nxt   = 8'd0;
            alive_nxt = ALL_ALIVE;
            if (!len_ok_r) begin
              ev_nxt = EV_OVERFLOW;
            end else begin
              left_nxt = len_r[15:0];
              if (len_r[15:0] != 16'd0) begin
                mode_nxt = MODE_PAYLOAD;
              end
            end
          end else begin
            if (in_rx_byte == CH_COMMA) begin
              len_nxt    = 17'd0;
              len_ok_nxt = 1'b0;
            end else if (is_digit) begin
              if (!len_r[16]) begin
                if (len_grown > LEN_MAX) begin
                  len_nxt    = 17'h10000;
                  len_ok_nxt = 1'b0;
                end else begin
                  len_nxt    = len_grown[16:0];
                  len_ok_nxt = 1'b1;
                end
              end
            end else begin
              len_nxt    = 17'h10000;
              len_ok_nxt = 1'b0;
            end
            hdr_nxt = hdr_bumped;
            // header over its limit with no colon: discard to end of line
            if ((7'(hdr_bumped) + 7'd5) > HEADER_LIMIT) begin
              ev_nxt = EV_OVERFLOW;
              if (in_rx_byte == CH_LF) begin
                mode_nxt  = MODE_START;
                cnt_nxt   = 8'd0;
                alive_nxt = ALL_ALIVE;
              end else begin
                mode_nxt = MODE_DISCARD;
              end
            end
          end
        end
        MODE_PAYLOAD: begin
          ev_nxt  = EV_PAYLOAD;
          pay_nxt = in_rx_byte;
          if (left_r <= 16'd1) begin
            left_nxt  = 16'd0;
            mode_nxt  = MODE_START;
            cnt_nxt   = 8'd0;
            alive_nxt = ALL_ALIVE;
          end else begin
            left_nxt = left_r - 16'd1;
          end
        end
        MODE_DISCARD: begin
          if (in_rx_byte == CH_LF) begin
            mode_nxt  = MODE_START;
            cnt_nxt   = 8'd0;
            alive_nxt = ALL_ALIVE;
          end
        end
        MODE_LINE, MODE_LINE_CR: begin
          mode_nxt  = line_mode;
          cnt_nxt   = line_cnt;
          alive_nxt = line_alive;
          ev_nxt    = line_ev;
          wifi_nxt  = line_wifi;
          tcp_nxt   = line_tcp;
          if (line_hdr_open) begin
            hdr_nxt    = 6'd0;
            len_nxt    = 17'd0;
            len_ok_nxt = 1'b0;
          end
        end
        default: begin
          // line start, and unused codes treated as line start
          if (in_rx_byte == CH_PROMPT) begin
            mode_nxt  = MODE_START;
            cnt_nxt   = 8'd0;
            alive_nxt = ALL_ALIVE;
            skip_nxt  = 1'b1;
            ev_nxt    = EV_PROMPT;
          end else begin
            mode_nxt  = line_mode;
            cnt_nxt   = line_cnt;
            alive_nxt = line_alive;
            ev_nxt    = line_ev;
            wifi_nxt  = line_wifi;
            tcp_nxt   = line_tcp;
            if (line_hdr_open) begin
              hdr_nxt    = 6'd0;
              len_nxt    = 17'd0;
              len_ok_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // Parser state register: advance on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_START;
      cnt_r    <= 8'd0;
      alive_r  <= ALL_ALIVE;
      hdr_r    <= 6'd0;
      len_r    <= 17'd0;
      len_ok_r <= 1'b0;
      left_r   <= 16'd0;
      skip_r   <= 1'b0;
      wifi_r   <= 1'b0;
      tcp_r    <= 1'b0;
    end else if (in_xfer) begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      alive_r  <= alive_nxt;
      hdr_r    <= hdr_nxt;
      len_r    <= len_nxt;
      len_ok_r <= len_ok_nxt;
      left_r   <= left_nxt;
      skip_r   <= skip_nxt;
      wifi_r   <= wifi_nxt;
      tcp_r    <= tcp_nxt;
    end
  end

  // Result register with one skid entry: hold a result the sink has stalled,
  // park the next one in the skid entry, refill from the skid when it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_xfer) begin
      if (skid_full_r) begin
        skid_full_r <= 1'b0;
      end else if (!in_xfer) begin
        out_valid_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer && skid_full_r) begin
      out_ev_r   <= skid_ev_r;
      out_pay_r  <= skid_pay_r;
      out_wifi_r <= skid_wifi_r;
      out_tcp_r  <= skid_tcp_r;
    end else if (in_xfer && (out_xfer || !out_valid_r)) begin
      out_ev_r   <= ev_nxt;
      out_pay_r  <= pay_nxt;
      out_wifi_r <= wifi_nxt;
      out_tcp_r  <= tcp_nxt;
    end
    if (in_xfer && out_valid_r && !out_xfer) begin
      skid_ev_r   <= ev_nxt;
      skid_pay_r  <= pay_nxt;
      skid_wifi_r <= wifi_nxt;
      skid_tcp_r  <= tcp_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_payload_byte = out_pay_r;
  assign out_wifi_up      = out_wifi_r;
  assign out_tcp_up       = out_tcp_r;

  // The skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid entry full with no result in the output register");

  // Payload data only travels with a payload event
  a_pay_only_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ev_r != EV_PAYLOAD)) |-> (out_pay_r == 8'h00))
    else $error("payload byte set on a non-payload event");

  // Payload mode always has bytes left to pass
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PAYLOAD) |-> (left_r != 16'd0))
    else $error("payload mode with no bytes left");

  // A pending prompt space only exists right after a prompt at line start
  a_skip_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (mode_r == MODE_START))
    else $error("prompt space skip pending outside line start");

  // A result transfer with nothing new behind it empties the output stage
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !skid_full_r && !in_xfer) |=> !out_valid_r)
    else $error("output register kept a result after it was taken");

endmodule
